// ===== rtl/photometric_pixel_correction_top_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the photometric pixel correction block.
// Each macro expects clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef PHOTOMETRIC_PIXEL_CORRECTION_TOP_ASSERT_SVH
`define PHOTOMETRIC_PIXEL_CORRECTION_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define PPC_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("photometric correction check failed");

// Next-cycle implication, checked outside reset
`define PPC_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("photometric correction check failed");

`endif

// ===== rtl/ppc_pkg.sv =====
// ---------------------------------------------------------------------------
// ppc_pkg
// Shared constants, codes and pipeline control type for the photometric
// pixel correction block.
// ---------------------------------------------------------------------------
package ppc_pkg;

  // Field widths
  localparam int ACTION_W = 2;
  localparam int CAMERA_W = 2;
  localparam int ADDR_W   = 18;
  localparam int VALUE_W  = 16;
  localparam int PIXEL_W  = 8;

  // Frame size and gain format
  localparam int unsigned PIXELS         = 262144;
  localparam int          GAIN_FRAC_BITS = 12;

  // Response table: 256 entries per camera, U8.8
  localparam int RESP_ENTRIES   = 256;
  localparam int RESP_FRAC_BITS = 8;
  localparam int RESP_IDX_W     = $clog2(RESP_ENTRIES);
  localparam int RESP_DEPTH     = 2 * RESP_ENTRIES;
  localparam int RESP_AW        = $clog2(RESP_DEPTH);

  // Gain map: PIXELS entries per camera
  localparam int GAIN_DEPTH = 2 * PIXELS;
  localparam int GAIN_AW    = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;

  // Product and rounding
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int RND_SHIFT = RESP_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int QUOT_W    = PROD_W - RND_SHIFT + 1;
  localparam logic [PIXEL_W-1:0] PIXEL_MAX = '1;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_LOAD_RESP = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOAD_GAIN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CORRECT   = 2'd2;

  // Camera codes
  localparam logic [CAMERA_W-1:0] CAM_FIRST  = 2'd0;
  localparam logic [CAMERA_W-1:0] CAM_SECOND = 2'd1;
  localparam logic [CAMERA_W-1:0] CAM_PASS   = 2'd2;

  // Control that travels with each pixel down the pipeline
  typedef struct packed {
    logic                valid;
    logic                pass;
    logic                oob;
    logic [CAMERA_W-1:0] camera;
    logic [ADDR_W-1:0]   index;
    logic [PIXEL_W-1:0]  pixel;
  } ppc_ctrl_t;

endpackage

// ===== rtl/ppc_if.sv =====
// ---------------------------------------------------------------------------
// ppc_in_if / ppc_out_if
// Valid/ready channels for input items and corrected pixels.
// ---------------------------------------------------------------------------
interface ppc_in_if;
  import ppc_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [CAMERA_W-1:0] camera;
  logic [ADDR_W-1:0]   address;
  logic [VALUE_W-1:0]  table_value;
  logic [PIXEL_W-1:0]  pixel_in;

  modport source (output valid, action, camera, address, table_value, pixel_in,
                  input ready);
  modport sink   (input valid, action, camera, address, table_value, pixel_in,
                  output ready);
endinterface

interface ppc_out_if;
  import ppc_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIXEL_W-1:0]  pixel_out;
  logic [ADDR_W-1:0]   pixel_index;
  logic [CAMERA_W-1:0] camera_out;

  modport source (output valid, pixel_out, pixel_index, camera_out, input ready);
  modport sink   (input valid, pixel_out, pixel_index, camera_out, output ready);
endinterface

// ===== rtl/ppc_store.sv =====
// ---------------------------------------------------------------------------
// ppc_store
// Response table and gain map memories; takes load and correct
// transactions and registers the looked-up entries (stage 1).
// ---------------------------------------------------------------------------
module ppc_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  ppc_in_if.sink                     item,
  output ppc_pkg::ppc_ctrl_t         ctrl1,
  output logic [ppc_pkg::VALUE_W-1:0] resp,
  output logic [ppc_pkg::VALUE_W-1:0] gain
);
  import ppc_pkg::*;

  logic [VALUE_W-1:0] resp_mem [RESP_DEPTH];
  logic [VALUE_W-1:0] gain_mem [GAIN_DEPTH];

  logic               accept;
  logic               cam_ok;
  logic               resp_we;
  logic               gain_we;
  logic               oob;
  logic [RESP_AW-1:0] resp_waddr;
  logic [RESP_AW-1:0] resp_raddr;
  logic [GAIN_AW-1:0] gain_addr;

  // Whole pipeline moves together
  assign item.ready = advance;
  assign accept     = item.valid && advance;

  // Decode
  assign cam_ok  = (item.camera == CAM_FIRST) || (item.camera == CAM_SECOND);
  assign oob     = 32'(item.address) >= PIXELS;
  assign resp_we = accept && (item.action == ACT_LOAD_RESP) && cam_ok &&
                   (32'(item.address) < RESP_ENTRIES);
  assign gain_we = accept && (item.action == ACT_LOAD_GAIN) && cam_ok && !oob;

  // Entry addresses: camera selects the half
  assign resp_waddr = {item.camera[0], item.address[RESP_IDX_W-1:0]};
  assign resp_raddr = {item.camera[0], item.pixel_in};
  assign gain_addr  = item.camera[0] ? GAIN_AW'(PIXELS) + GAIN_AW'(item.address)
                                     : GAIN_AW'(item.address);

  // Response table: one write, one registered read
  always_ff @(posedge clk) begin
    if (resp_we) begin
      resp_mem[resp_waddr] <= item.table_value;
    end
    if (advance) begin
      resp <= resp_mem[resp_raddr];
    end
  end

  // Gain map: one write, one registered read
  always_ff @(posedge clk) begin
    if (gain_we) begin
      gain_mem[gain_addr] <= item.table_value;
    end
    if (advance) begin
      gain <= gain_mem[gain_addr];
    end
  end

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1.valid <= 1'b0;
    end else if (advance) begin
      ctrl1.valid <= accept && (item.action == ACT_CORRECT);
    end
    if (advance) begin
      ctrl1.pass   <= !cam_ok;
      ctrl1.oob    <= oob;
      ctrl1.camera <= item.camera;
      ctrl1.index  <= item.address;
      ctrl1.pixel  <= item.pixel_in;
    end
  end

endmodule

// ===== rtl/ppc_scale.sv =====
// ---------------------------------------------------------------------------
// ppc_scale
// Stage 2: multiplies the response entry by the vignette gain.
// ---------------------------------------------------------------------------
module ppc_scale (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  ppc_pkg::ppc_ctrl_t          ctrl1,
  input  logic [ppc_pkg::VALUE_W-1:0] resp,
  input  logic [ppc_pkg::VALUE_W-1:0] gain,
  output ppc_pkg::ppc_ctrl_t          ctrl2,
  output logic [ppc_pkg::PROD_W-1:0]  product
);
  import ppc_pkg::*;

  // 16x16 multiply, registered
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl2.valid <= 1'b0;
    end else if (advance) begin
      ctrl2.valid <= ctrl1.valid;
    end
    if (advance) begin
      ctrl2.pass   <= ctrl1.pass;
      ctrl2.oob    <= ctrl1.oob;
      ctrl2.camera <= ctrl1.camera;
      ctrl2.index  <= ctrl1.index;
      ctrl2.pixel  <= ctrl1.pixel;
      product      <= PROD_W'(resp) * PROD_W'(gain);
    end
  end

endmodule

// ===== rtl/ppc_round.sv =====
// ---------------------------------------------------------------------------
// ppc_round
// Stage 3: round half to even, saturate, select pass-through or zero,
// and hold the result in the output register.
// ---------------------------------------------------------------------------
module ppc_round (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  ppc_pkg::ppc_ctrl_t         ctrl2,
  input  logic [ppc_pkg::PROD_W-1:0] product,
  ppc_out_if.source                  result
);
  import ppc_pkg::*;

  logic [QUOT_W-1:0]  quot;
  logic [QUOT_W-1:0]  rounded;
  logic               half;
  logic               below;
  logic               round_up;
  logic [PIXEL_W-1:0] sat;
  logic [PIXEL_W-1:0] pixel_next;

  // Round half to even on the dropped fraction
  assign quot     = QUOT_W'(product >> RND_SHIFT);
  assign half     = product[RND_SHIFT-1];
  assign below    = product[RND_SHIFT-2:0] != '0;
  assign round_up = half && (below || quot[0]);
  assign rounded  = quot + QUOT_W'(round_up);
  assign sat      = (rounded > QUOT_W'(PIXEL_MAX)) ? PIXEL_MAX : rounded[PIXEL_W-1:0];

  // Pass-through wins, then out-of-frame gives zero
  always_comb begin
    if (ctrl2.pass) begin
      pixel_next = ctrl2.pixel;
    end else if (ctrl2.oob) begin
      pixel_next = '0;
    end else begin
      pixel_next = sat;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= ctrl2.valid;
    end
    if (advance) begin
      result.pixel_out   <= pixel_next;
      result.pixel_index <= ctrl2.index;
      result.camera_out  <= ctrl2.camera;
    end
  end

endmodule

// ===== rtl/photometric_pixel_correction_top.sv =====
// Photometric pixel correction: takes one transaction per clock while not
// stalled and returns one corrected pixel per correct transaction, passed in
// turn through the memory read, multiply, and round and saturate registers,
// at a sustained rate of one pixel per clock; load transactions give no
// result. The whole pipeline stalls together when the output is held, so the
// rate is set only by the output handshake. Tables start undefined and must
// be loaded before they are used; a load may be followed by a correct
// transaction reading the same entry in the next cycle.
// ---------------------------------------------------------------------------
// photometric_pixel_correction_top
// Inverse response lookup and flat-field gain for two cameras, with a
// pass-through camera code.
// ---------------------------------------------------------------------------
`include "photometric_pixel_correction_top_assert.svh"

module photometric_pixel_correction_top (
  input logic       clk,
  input logic       rst,
  ppc_in_if.sink    item,
  ppc_out_if.source result
);
  import ppc_pkg::*;

  logic               advance;
  ppc_ctrl_t          ctrl1;
  ppc_ctrl_t          ctrl2;
  logic [VALUE_W-1:0] resp;
  logic [VALUE_W-1:0] gain;
  logic [PROD_W-1:0]  product;

  // Pipeline moves whenever the output register is free or being taken
  assign advance = !result.valid || result.ready;

  ppc_store u_store (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .ctrl1   (ctrl1),
    .resp    (resp),
    .gain    (gain)
  );

  ppc_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ctrl1   (ctrl1),
    .resp    (resp),
    .gain    (gain),
    .ctrl2   (ctrl2),
    .product (product)
  );

  ppc_round u_round (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ctrl2   (ctrl2),
    .product (product),
    .result  (result)
  );

  // Only correct transactions enter the pipeline
  `PPC_ASSERT_NEXT(a_correct_enters, item.valid && item.ready && item.action == ACT_CORRECT, ctrl1.valid)
  `PPC_ASSERT_NEXT(a_load_no_slot, item.valid && item.ready && item.action != ACT_CORRECT, !ctrl1.valid)
  // A stall holds stage 2 in place
  `PPC_ASSERT_NEXT(a_stall_holds, !advance && ctrl2.valid, ctrl2.valid && $stable(product))
  // Out-of-frame pixels for a real camera come out as zero
  `PPC_ASSERT_NEXT(a_oob_zero, advance && ctrl2.valid && ctrl2.oob && !ctrl2.pass, result.pixel_out == '0)

endmodule

// ===== test/ppc_correction_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ppc_correction_checker
// Watches the item and result channels of the photometric pixel correction
// block. Keeps its own copy of both cameras' response tables and gain maps,
// predicts each corrected pixel and compares it, field by field, with the
// oldest one still awaited. Reports the mismatch, pending and match counts to the testbench top.
// ---------------------------------------------------------------------------
module ppc_correction_checker (
  input  logic        clk,
  input  logic        rst,
  ppc_in_if           item,
  ppc_out_if          result,
  output int unsigned errors,
  output int unsigned pending,
  output int unsigned checked
);
  import ppc_pkg::*;

  // One corrected pixel as it leaves the block
  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel;
    logic [ADDR_W-1:0]   index;
    logic [CAMERA_W-1:0] camera;
  } corrected_t;

  localparam int FRAC_TOTAL  = RESP_FRAC_BITS + GAIN_FRAC_BITS;
  localparam int MAX_REPORTS = 10;

  // Shadow stores, keyed by camera * depth + index
  logic [VALUE_W-1:0] response_lut [int];
  logic [VALUE_W-1:0] gain_lut     [int];
  corrected_t         awaited_q[$];
  int unsigned        fail_count;
  int unsigned        match_count;

  // U8.8 x U4.12 product, round half to even, clamp to 8 bits
  function automatic logic [PIXEL_W-1:0] flat_field(input logic [VALUE_W-1:0] resp,
                                                    input logic [VALUE_W-1:0] gain);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] whole;
    logic [PROD_W-1:0] frac;
    logic [PROD_W-1:0] half;
    prod  = PROD_W'(resp) * PROD_W'(gain);
    whole = prod >> FRAC_TOTAL;
    frac  = prod & ((PROD_W'(1) << FRAC_TOTAL) - PROD_W'(1));
    half  = PROD_W'(1) << (FRAC_TOTAL - 1);
    if (frac > half || (frac == half && whole[0])) begin
      whole = whole + PROD_W'(1);
    end
    return (whole > PROD_W'(PIXEL_MAX)) ? PIXEL_MAX : whole[PIXEL_W-1:0];
  endfunction

  // Expected output for one correct transaction
  function automatic corrected_t predict(input logic [CAMERA_W-1:0] cam,
                                         input logic [ADDR_W-1:0]   addr,
                                         input logic [PIXEL_W-1:0]  pix);
    corrected_t         r;
    int                 rk;
    int                 gk;
    logic [VALUE_W-1:0] resp;
    logic [VALUE_W-1:0] gain;
    r.index  = addr;
    r.camera = cam;
    if (cam >= CAM_PASS) begin
      r.pixel = pix;
    end else if (addr >= PIXELS) begin
      r.pixel = '0;
    end else begin
      rk      = int'(cam) * RESP_ENTRIES + int'(pix);
      gk      = int'(cam) * int'(PIXELS) + int'(addr);
      resp    = response_lut.exists(rk) ? response_lut[rk] : '0;
      gain    = gain_lut.exists(gk) ? gain_lut[gk] : '0;
      r.pixel = flat_field(resp, gain);
    end
    return r;
  endfunction

  task automatic report_miss(input string what, input corrected_t want,
                             input corrected_t got);
    if (fail_count < MAX_REPORTS) begin
      $display("%0t: %s: expected pixel %0d index %0d camera %0d, %s",
               $realtime, what, want.pixel, want.index, want.camera,
               $sformatf("got pixel %0d index %0d camera %0d",
                         got.pixel, got.index, got.camera));
    end
    fail_count++;
  endtask

  // Results are taken before items: an item never answers in its own cycle
  always @(posedge clk) begin : watch
    corrected_t got;
    corrected_t want;
    if (rst) begin
      awaited_q.delete();
      fail_count  = 0;
      match_count = 0;
    end else begin
      if (result.valid && result.ready) begin
        got.pixel  = result.pixel_out;
        got.index  = result.pixel_index;
        got.camera = result.camera_out;
        if (awaited_q.size() == 0) begin
          report_miss("unexpected pixel", '0, got);
        end else begin
          want = awaited_q.pop_front();
          if (got.pixel !== want.pixel || got.index !== want.index ||
              got.camera !== want.camera) begin
            report_miss("pixel mismatch", want, got);
          end else begin
            match_count++;
          end
        end
      end

      if (item.valid && item.ready) begin
        case (item.action)
          ACT_LOAD_RESP: begin
            if (item.camera < CAM_PASS && item.address < RESP_ENTRIES) begin
              response_lut[int'(item.camera) * RESP_ENTRIES + int'(item.address)] =
                item.table_value;
            end
          end
          ACT_LOAD_GAIN: begin
            if (item.camera < CAM_PASS && item.address < PIXELS) begin
              gain_lut[int'(item.camera) * int'(PIXELS) + int'(item.address)] =
                item.table_value;
            end
          end
          ACT_CORRECT: begin
            awaited_q.push_back(predict(item.camera, item.address, item.pixel_in));
          end
          default: begin
          end
        endcase
      end
    end
    errors  <= fail_count;
    pending <= awaited_q.size();
    checked <= match_count;
  end

endmodule

// ===== test/photometric_pixel_correction_top_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// photometric_pixel_correction_top_tb
// Drives load and correct transactions into the photometric correction
// block with random gaps and output back-pressure. A directed opening covers
// table extremes, rounding ties, saturation, pass-through and ignored codes;
// the random part loads tables and streams pixels that read loaded entries.
// ---------------------------------------------------------------------------
module photometric_pixel_correction_top_tb;
  import ppc_pkg::*;

  // Codes the block treats as spare
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam logic [CAMERA_W-1:0] CAM_SPARE = 2'd3;

  localparam int PIPE_DEPTH   = 3;
  localparam int RANDOM_ITEMS = 500;
  localparam int ADDR_MAX     = (1 << ADDR_W) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ppc_in_if  item_ch ();
  ppc_out_if result_ch ();

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;

  bit quiet = 1'b0;

  // Entries loaded so far, so that no correct reads an unwritten entry
  bit                    resp_loaded [2][RESP_ENTRIES];
  logic [RESP_IDX_W-1:0] resp_idx_q  [2][$];
  bit                    gain_loaded [int];
  logic [ADDR_W-1:0]     gain_addr_q [2][$];

  int unsigned items_sent;
  int unsigned resp_loads;
  int unsigned gain_loads;
  int unsigned pixels_sent;
  int unsigned ignored_sent;
  int unsigned stall_left;

  photometric_pixel_correction_top uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ppc_correction_checker checker_i (
    .clk     (clk),
    .rst     (rst),
    .item    (item_ch),
    .result  (result_ch),
    .errors  (errors),
    .pending (pending),
    .checked (checked)
  );

  // 50 MHz clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length: mostly none, some short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) begin
      return 0;
    end else if (r < 95) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left      <= 0;
    end else if (stall_left != 0) begin
      result_ch.ready <= 1'b0;
      stall_left      <= stall_left - 1;
    end else begin
      result_ch.ready <= 1'b1;
      stall_left      <= gap_len();
    end
  end

  // One transaction: optional idle, then hold until accepted
  task automatic send(input logic [ACTION_W-1:0] act, input logic [CAMERA_W-1:0] cam,
                      input logic [ADDR_W-1:0] addr, input logic [VALUE_W-1:0] value,
                      input logic [PIXEL_W-1:0] pix);
    int unsigned gap;
    int          key;
    gap = gap_len();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.action      <= act;
    item_ch.camera      <= cam;
    item_ch.address     <= addr;
    item_ch.table_value <= value;
    item_ch.pixel_in    <= pix;
    do @(posedge clk); while (!item_ch.ready);

    if (act == ACT_LOAD_RESP && cam < CAM_PASS && addr < RESP_ENTRIES) begin
      if (!resp_loaded[cam[0]][addr[RESP_IDX_W-1:0]]) begin
        resp_loaded[cam[0]][addr[RESP_IDX_W-1:0]] = 1'b1;
        resp_idx_q[cam[0]].push_back(addr[RESP_IDX_W-1:0]);
      end
      resp_loads++;
      items_sent++;
    end else if (act == ACT_LOAD_GAIN && cam < CAM_PASS && addr < PIXELS) begin
      key = int'(cam[0]) * int'(PIXELS) + int'(addr);
      if (!gain_loaded.exists(key)) begin
        gain_loaded[key] = 1'b1;
        gain_addr_q[cam[0]].push_back(addr);
      end
      gain_loads++;
      items_sent++;
    end else if (act == ACT_CORRECT) begin
      pixels_sent++;
      items_sent++;
    end else begin
      ignored_sent++;
    end
  endtask

  // Stop sending until every awaited pixel is out
  task automatic drain();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] resp_value();
    logic [VALUE_W-1:0] v;
    v = VALUE_W'($urandom);
    // tie on the rounding boundary now and then
    if ($urandom_range(0, 9) == 0) begin
      v[7:0] = 8'h80;
    end
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] gain_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      return 16'h1000;
    end else if (r < 65) begin
      return VALUE_W'($urandom_range(16'h0800, 16'h1800));
    end else if (r < 80) begin
      return VALUE_W'($urandom_range(0, 16'h07FF));
    end
    return VALUE_W'($urandom);
  endfunction

  // A run of pixels that only read loaded entries
  task automatic pixel_run(input logic [CAMERA_W-1:0] cam, input int unsigned n);
    logic [ADDR_W-1:0]     addr;
    logic [RESP_IDX_W-1:0] idx;
    if (resp_idx_q[cam[0]].size() == 0) begin
      send(ACT_LOAD_RESP, cam, ADDR_W'($urandom_range(0, RESP_ENTRIES - 1)), resp_value(),
           PIXEL_W'($urandom));
    end
    if (gain_addr_q[cam[0]].size() == 0) begin
      send(ACT_LOAD_GAIN, cam, ADDR_W'($urandom_range(0, ADDR_MAX)), gain_value(),
           PIXEL_W'($urandom));
    end
    repeat (n) begin
      addr = gain_addr_q[cam[0]][$urandom_range(0, gain_addr_q[cam[0]].size() - 1)];
      idx  = resp_idx_q[cam[0]][$urandom_range(0, resp_idx_q[cam[0]].size() - 1)];
      send(ACT_CORRECT, cam, addr, VALUE_W'($urandom), idx);
    end
  endtask

  initial begin : stimulus
    int unsigned         target;
    int unsigned         sel;
    logic [CAMERA_W-1:0] cam;
    logic [ADDR_W-1:0]   addr;
    bit                  paused;
    item_ch.valid       <= 1'b0;
    item_ch.action      <= ACT_LOAD_RESP;
    item_ch.camera      <= CAM_FIRST;
    item_ch.address     <= '0;
    item_ch.table_value <= '0;
    item_ch.pixel_in    <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: table extremes, rounding ties, saturation
    send(ACT_LOAD_RESP, CAM_FIRST, 18'd0, 16'h0000, 8'h00);
    send(ACT_LOAD_RESP, CAM_FIRST, 18'd255, 16'hFFFF, 8'hFF);
    send(ACT_LOAD_RESP, CAM_SECOND, 18'd128, 16'h0180, 8'h00);
    send(ACT_LOAD_RESP, CAM_SECOND, 18'd1, 16'h0280, 8'h00);
    send(ACT_LOAD_GAIN, CAM_FIRST, 18'd0, 16'h1000, 8'h00);
    send(ACT_LOAD_GAIN, CAM_FIRST, 18'h3FFFF, 16'hFFFF, 8'h00);
    send(ACT_LOAD_GAIN, CAM_SECOND, 18'h2AAAA, 16'h1000, 8'h00);
    send(ACT_CORRECT, CAM_FIRST, 18'd0, 16'hFFFF, 8'h00);
    send(ACT_CORRECT, CAM_FIRST, 18'h3FFFF, 16'h0000, 8'hFF);
    send(ACT_CORRECT, CAM_FIRST, 18'd0, 16'h0000, 8'hFF);
    // 1.5 rounds up to 2, 2.5 rounds down to 2
    send(ACT_CORRECT, CAM_SECOND, 18'h2AAAA, 16'h0000, 8'd128);
    send(ACT_CORRECT, CAM_SECOND, 18'h2AAAA, 16'h0000, 8'd1);
    // gain written and read back to back
    send(ACT_LOAD_GAIN, CAM_SECOND, 18'h15555, 16'h0000, 8'h00);
    send(ACT_CORRECT, CAM_SECOND, 18'h15555, 16'h0000, 8'd128);
    // pass-through on both spare camera codes
    send(ACT_CORRECT, CAM_PASS, 18'h3FFFF, 16'hFFFF, 8'hA5);
    send(ACT_CORRECT, CAM_SPARE, 18'd0, 16'h0000, 8'h5A);
    // ignored: spare action, loads for no camera, response index past the table
    send(ACT_SPARE, CAM_FIRST, 18'd0, 16'hFFFF, 8'hFF);
    send(ACT_LOAD_RESP, CAM_PASS, 18'd0, 16'hFFFF, 8'h00);
    send(ACT_LOAD_GAIN, CAM_SPARE, 18'd0, 16'hFFFF, 8'h00);
    send(ACT_LOAD_RESP, CAM_FIRST, 18'd256, 16'hFFFF, 8'h00);
    send(ACT_LOAD_RESP, CAM_FIRST, 18'h3FFFF, 16'hFFFF, 8'h00);
    send(ACT_CORRECT, CAM_FIRST, 18'd0, 16'h0000, 8'h00);
    drain();

    // Random: table loads with pixel runs, some pass-through and noise
    target = items_sent + RANDOM_ITEMS;
    paused = 1'b0;
    while (items_sent < target) begin
      quiet = ((items_sent / 60) % 4) == 3;
      if (!paused && items_sent + RANDOM_ITEMS / 2 >= target) begin
        drain();
        paused = 1'b1;
      end
      sel = $urandom_range(0, 99);
      cam = CAMERA_W'($urandom_range(0, 1));
      if (sel < 12) begin
        send(ACT_LOAD_RESP, cam, ADDR_W'($urandom_range(0, RESP_ENTRIES - 1)), resp_value(),
             PIXEL_W'($urandom));
      end else if (sel < 27) begin
        addr = ADDR_W'($urandom_range(0, ADDR_MAX));
        send(ACT_LOAD_GAIN, cam, addr, gain_value(), PIXEL_W'($urandom));
        if (resp_idx_q[cam[0]].size() != 0) begin
          repeat ($urandom_range(1, 4)) begin
            send(ACT_CORRECT, cam, addr, VALUE_W'($urandom),
                 resp_idx_q[cam[0]][$urandom_range(0, resp_idx_q[cam[0]].size() - 1)]);
          end
        end
      end else if (sel < 77) begin
        pixel_run(cam, $urandom_range(1, 8));
      end else if (sel < 87) begin
        send(ACT_CORRECT, CAMERA_W'($urandom_range(CAM_PASS, CAM_SPARE)),
             ADDR_W'($urandom_range(0, ADDR_MAX)), VALUE_W'($urandom), PIXEL_W'($urandom));
      end else begin
        case ($urandom_range(0, 2))
          0: send(ACT_SPARE, CAMERA_W'($urandom_range(0, 3)),
                  ADDR_W'($urandom_range(0, ADDR_MAX)), VALUE_W'($urandom),
                  PIXEL_W'($urandom));
          1: send(ACTION_W'($urandom_range(ACT_LOAD_RESP, ACT_LOAD_GAIN)),
                  CAMERA_W'($urandom_range(CAM_PASS, CAM_SPARE)),
                  ADDR_W'($urandom_range(0, ADDR_MAX)), VALUE_W'($urandom),
                  PIXEL_W'($urandom));
          default: send(ACT_LOAD_RESP, cam, ADDR_W'($urandom_range(RESP_ENTRIES, ADDR_MAX)),
                        VALUE_W'($urandom), PIXEL_W'($urandom));
        endcase
      end
    end
    quiet = 1'b0;
    drain();

    $display("Run covered %0d transactions: %0d response loads, %0d gain loads, %0d pixels",
             items_sent, resp_loads, gain_loads, pixels_sent);
    $display("plus %0d ignored transactions; %0d corrected pixels matched",
             ignored_sent, checked);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Timed out with %0d pixels still awaited", pending);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/ppc_pkg.sv
rtl/ppc_if.sv
rtl/ppc_store.sv
rtl/ppc_scale.sv
rtl/ppc_round.sv
rtl/photometric_pixel_correction_top.sv
test/ppc_correction_checker.sv
test/photometric_pixel_correction_top_tb.sv
